FILE: sv/etg_pkg.sv
`timescale 1ns / 1ps

package etg_pkg;

  localparam int VAL_W  = 16;
  localparam int TIME_W = 16;
  localparam int FRAC_W = 16;
  localparam int RATE_W = FRAC_W + 1;
  localparam int MUL_W  = ((VAL_W > FRAC_W) ? VAL_W : FRAC_W) + 2;
  localparam int PROD_W = 2 * MUL_W;
  localparam int E2_W   = 2 * FRAC_W + 3;
  localparam int CFG_W  = (VAL_W > TIME_W) ? VAL_W : TIME_W;
  localparam int CURVE_W = 3;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_START = 2'd1,
    ACT_STOP  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  localparam logic [1:0] CFG_START    = 2'd0;
  localparam logic [1:0] CFG_END      = 2'd1;
  localparam logic [1:0] CFG_DURATION = 2'd2;
  localparam logic [1:0] CFG_CURVE    = 2'd3;

  localparam logic [CURVE_W-1:0] CURVE_IN_QUAD     = 3'd1;
  localparam logic [CURVE_W-1:0] CURVE_OUT_QUAD    = 3'd2;
  localparam logic [CURVE_W-1:0] CURVE_IN_OUT_QUAD = 3'd3;
  localparam logic [CURVE_W-1:0] CURVE_OUT_IN_QUAD = 3'd4;

  typedef struct packed {
    logic [1:0]        action;
    logic [TIME_W-1:0] tick_count;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] eased_value;
    logic [TIME_W-1:0]       elapsed_ticks;
    logic                    still_running;
  } out_item_t;

endpackage

FILE: sv/etg_div.sv
`timescale 1ns / 1ps

module etg_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [etg_pkg::TIME_W-1:0]    dividend,
  input  logic [etg_pkg::TIME_W-1:0]    divisor,
  output logic                          done,
  output logic [etg_pkg::RATE_W-1:0]    quotient
);

  localparam int CNT_W = $clog2(etg_pkg::RATE_W);

  logic                         busy_r;
  logic                         done_r;
  logic [CNT_W-1:0]             cnt_r;
  logic [etg_pkg::TIME_W:0]     rem_r;
  logic [etg_pkg::TIME_W-1:0]   dsr_r;
  logic [etg_pkg::RATE_W-1:0]   quo_r;

  logic                         ge;
  logic [etg_pkg::TIME_W:0]     diff;
  logic [etg_pkg::TIME_W:0]     sel;
  logic [etg_pkg::TIME_W:0]     rem_nxt;
  logic [etg_pkg::RATE_W-1:0]   quo_nxt;

  // restoring division, one quotient bit per cycle
  always_comb begin
    ge      = rem_r >= {1'b0, dsr_r};
    diff    = rem_r - {1'b0, dsr_r};
    sel     = ge ? diff : rem_r;
    rem_nxt = {sel[etg_pkg::TIME_W-1:0], 1'b0};
    quo_nxt = {quo_r[etg_pkg::RATE_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= {1'b0, dividend};
        dsr_r  <= divisor;
        quo_r  <= '0;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        quo_r <= quo_nxt;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(etg_pkg::FRAC_W)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

FILE: sv/etg_mul.sv
`timescale 1ns / 1ps

module etg_mul (
  input  logic                                clk,
  input  logic signed [etg_pkg::MUL_W-1:0]    op_a,
  input  logic signed [etg_pkg::MUL_W-1:0]    op_b,
  output logic signed [etg_pkg::PROD_W-1:0]   prod
);

  logic signed [etg_pkg::PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

  assign prod = prod_r;

endmodule

FILE: sv/easing_tween_generator_unit.sv
`timescale 1ns / 1ps
// an input beat is taken only in S_IDLE; the serial rate divider then works
//   one quotient bit a cycle, followed by two passes through the shared multiplier;
//   a result waits in S_FIN on a stalled output; new items wait till it is registered
// stop, idle ticks and unknown actions are taken in S_IDLE and give no result
// reset: synchronous active low; clears elapsed time, running flag and output valid,
//   and loads start 0, end 0, duration 1, linear curve

module easing_tween_generator_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  etg_pkg::in_item_t            in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output etg_pkg::out_item_t           out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [1:0]                   cfg_index,
  input  logic [etg_pkg::CFG_W-1:0]    cfg_data
);

  localparam int V = etg_pkg::VAL_W;
  localparam int T = etg_pkg::TIME_W;
  localparam int F = etg_pkg::FRAC_W;
  localparam int R = etg_pkg::RATE_W;
  localparam int M = etg_pkg::MUL_W;
  localparam int P = etg_pkg::PROD_W;
  localparam int E = etg_pkg::E2_W;

  localparam logic [R-1:0] RATE_HALF = R'(1) << (F - 1);
  localparam logic [E-1:0] E2_HALF   = E'(1) << (F - 1);
  localparam logic [E-1:0] E2_ONE    = E'(1) << (2 * F);
  localparam logic [P-1:0] P_HALF    = P'(1) << (F - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_PREP, S_DIV, S_SQ, S_EASE, S_SCALE, S_FIN
  } state_t;

  state_t                         state_r;
  logic [V-1:0]                   start_r;
  logic [V-1:0]                   end_r;
  logic [T-1:0]                   dur_r;
  logic [etg_pkg::CURVE_W-1:0]    curve_r;
  logic [T-1:0]                   elapsed_r;
  logic                           active_r;
  logic [R-1:0]                   rate_r;
  logic [R-1:0]                   frac_r;
  logic                           out_valid_r;
  etg_pkg::out_item_t             out_data_r;

  logic [T-1:0]                   dur_eff;
  logic [T:0]                     tick_sum;
  logic [T-1:0]                   tick_clamped;
  logic                           div_start;
  logic                           div_done;
  logic [R-1:0]                   div_quo;
  logic signed [M-1:0]            mul_a;
  logic signed [M-1:0]            mul_b;
  logic signed [P-1:0]            mul_prod;
  logic [V:0]                     range;
  logic [E-1:0]                   sq;
  logic [E-1:0]                   lin;
  logic [E-1:0]                   e2;
  logic [E-1:0]                   e2_rnd;
  logic [P-1:0]                   p_rnd;
  logic [V-1:0]                   value;
  etg_pkg::action_t               act;

  assign dur_eff      = (dur_r == '0) ? T'(1) : dur_r;
  assign tick_sum     = {1'b0, elapsed_r} + {1'b0, in_data.tick_count};
  assign tick_clamped = (tick_sum > {1'b0, dur_eff}) ? dur_eff : tick_sum[T-1:0];
  assign act          = etg_pkg::action_t'(in_data.action);
  assign div_start    = (state_r == S_PREP);
  assign range        = {end_r[V-1], end_r} - {start_r[V-1], start_r};

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  etg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (elapsed_r),
    .divisor  (dur_eff),
    .done     (div_done),
    .quotient (div_quo)
  );

  etg_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (mul_prod)
  );

  // shared multiplier: rate squared, then range times eased fraction
  always_comb begin
    if (state_r == S_SCALE || state_r == S_FIN) begin
      mul_a = M'($signed(range));
      mul_b = $signed(M'(frac_r));
    end else begin
      mul_a = $signed(M'(rate_r));
      mul_b = $signed(M'(rate_r));
    end
  end

  always_comb begin
    sq  = E'(mul_prod[2*F+1:0]);
    lin = E'(rate_r) << F;
    unique case (curve_r)
      etg_pkg::CURVE_IN_QUAD:     e2 = sq;
      etg_pkg::CURVE_OUT_QUAD:    e2 = (lin << 1) - sq;
      etg_pkg::CURVE_IN_OUT_QUAD: begin
        if (rate_r < RATE_HALF) e2 = sq << 1;
        else e2 = (lin << 2) - (sq << 1) - E2_ONE;
      end
      etg_pkg::CURVE_OUT_IN_QUAD: begin
        if (rate_r < RATE_HALF) e2 = (lin << 1) - (sq << 1);
        else e2 = (sq << 1) - (lin << 1) + E2_ONE;
      end
      default: e2 = lin;
    endcase
    e2_rnd = (e2 + E2_HALF) >> F;
    p_rnd  = $unsigned(mul_prod) + P_HALF;
    value  = start_r + p_rnd[F+V-1:F];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      start_r     <= '0;
      end_r       <= '0;
      dur_r       <= T'(1);
      curve_r     <= '0;
      elapsed_r   <= '0;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && state_r != S_FIN) out_valid_r <= 1'b0;
      if (cfg_valid) begin
        unique case (cfg_index)
          etg_pkg::CFG_START:    start_r <= cfg_data[V-1:0];
          etg_pkg::CFG_END:      end_r   <= cfg_data[V-1:0];
          etg_pkg::CFG_DURATION: dur_r   <= cfg_data[T-1:0];
          etg_pkg::CFG_CURVE:    curve_r <= cfg_data[etg_pkg::CURVE_W-1:0];
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            unique case (act)
              etg_pkg::ACT_START: begin
                elapsed_r <= '0;
                active_r  <= 1'b1;
                state_r   <= S_PREP;
              end
              etg_pkg::ACT_STOP: active_r <= 1'b0;
              etg_pkg::ACT_TICK: begin
                if (!active_r || elapsed_r >= dur_eff) begin
                  if (elapsed_r > dur_eff) elapsed_r <= dur_eff;
                end else begin
                  elapsed_r <= tick_clamped;
                  state_r   <= S_PREP;
                end
              end
              default: ;
            endcase
          end
        end
        S_PREP: state_r <= S_DIV;
        S_DIV: begin
          if (div_done) begin
            rate_r  <= div_quo;
            state_r <= S_SQ;
          end
        end
        S_SQ: state_r <= S_EASE;
        S_EASE: begin
          frac_r  <= e2_rnd[R-1:0];
          state_r <= S_SCALE;
        end
        S_SCALE: state_r <= S_FIN;
        S_FIN: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r                <= 1'b1;
            out_data_r.eased_value     <= value;
            out_data_r.elapsed_ticks   <= elapsed_r;
            out_data_r.still_running   <= active_r && (elapsed_r < dur_eff);
            state_r                    <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
